// ===== hdl/ogrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid ray caster package
// Shared types, codes and constants of the grid ray caster.
// ----------------------------------------------------------------------------
package ogrc_pkg;

	// Grid geometry
	localparam int MAP_W       = 128;
	localparam int MAP_H       = 128;
	localparam int HALF_W      = MAP_W / 2;
	localparam int HALF_H      = MAP_H / 2;
	localparam int GRID_CELLS  = MAP_W * MAP_H;
	localparam int ADDR_W      = $clog2(GRID_CELLS);
	localparam int CENTER_ADDR = HALF_H * MAP_W + HALF_W;
	localparam int MAX_BEAMS   = 4096;

	// Request function codes
	localparam logic [1:0] FUNC_SCAN = 2'd0;
	localparam logic [1:0] FUNC_BEAM = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	// Cell codes
	localparam logic [1:0] CELL_UNKNOWN = 2'd0;
	localparam logic [1:0] CELL_FREE    = 2'd1;
	localparam logic [1:0] CELL_OCC     = 2'd2;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] CFG_HEADING     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_START = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_STEP  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_MIN   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_MAX   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_CELL_SIZE   = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_MARCH_STEP  = 3'd6;

	// CORDIC datapath
	localparam int CORDIC_ITERS = 16;
	localparam int ITER_W       = $clog2(CORDIC_ITERS);
	localparam int XY_W         = 34;
	localparam int Z_W          = 25;
	localparam logic signed [XY_W-1:0] CORDIC_K0 = 34'sd652032874;

	// Cell coordinate datapath
	localparam int FRAC_SH  = 30;
	localparam int P_W      = 19;
	localparam int DIV_W    = P_W - 1;
	localparam int DIV_CW   = $clog2(DIV_W + 1);
	localparam int Q_W      = DIV_W + 2;

	// Command queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [1:0]  func;
		logic [11:0] beam_index;
		logic [15:0] range_mm;
		logic [13:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  cell_state;
		logic [13:0] read_index;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        heading;
		logic signed [15:0] angle_start;
		logic signed [15:0] angle_step;
		logic [15:0]        range_min_mm;
		logic [15:0]        range_max_mm;
		logic [15:0]        cell_size_mm;
		logic [15:0]        march_step_mm;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_SCAN,
		CMD_BEAM,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic signed [XY_W-1:0] cos_v;
		logic signed [XY_W-1:0] sin_v;
		logic [15:0]           range_mm;
		logic [13:0]           cell_index;
	} cmd_t;

	// Arctangent of 2^-i in 2^-24 turn units.
	function automatic logic signed [Z_W-1:0] cordic_atan(input logic [ITER_W-1:0] i);
		logic signed [Z_W-1:0] a;
		case (i)
			4'd0:  a = 25'sd2097152;
			4'd1:  a = 25'sd1238021;
			4'd2:  a = 25'sd654136;
			4'd3:  a = 25'sd332050;
			4'd4:  a = 25'sd166669;
			4'd5:  a = 25'sd83416;
			4'd6:  a = 25'sd41718;
			4'd7:  a = 25'sd20860;
			4'd8:  a = 25'sd10430;
			4'd9:  a = 25'sd5215;
			4'd10: a = 25'sd2608;
			4'd11: a = 25'sd1304;
			4'd12: a = 25'sd652;
			4'd13: a = 25'sd326;
			4'd14: a = 25'sd163;
			default: a = 25'sd81;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/ogrc_front.sv =====
// ----------------------------------------------------------------------------
// Ray caster front end
// Accepts requests, drops invalid beams, forms the beam angle and runs the
// CORDIC rotation, then hands commands to the queue.
// ----------------------------------------------------------------------------
module ogrc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ogrc_pkg::req_t req,
	input  ogrc_pkg::cfg_t cfg,
	input  logic           init_busy,
	input  logic           full,
	output logic           busy,
	output logic           push,
	output ogrc_pkg::cmd_t push_data
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_ROT,
		F_PUSH
	} fstate_t;

	fstate_t state_q;
	logic signed [ogrc_pkg::XY_W-1:0] x_q, y_q;
	logic signed [ogrc_pkg::Z_W-1:0]  z_q;
	logic [ogrc_pkg::ITER_W-1:0]      iter_q;
	logic                             neg_q;
	logic [15:0]                      range_q;

	logic                             accept;
	logic                             beam_ok;
	logic [27:0]                      bprod;
	logic [15:0]                      theta;
	logic                             fold;
	logic [15:0]                      t_fold;
	logic signed [ogrc_pkg::XY_W-1:0] dx, dy;
	logic signed [ogrc_pkg::Z_W-1:0]  atan_i;

	// Request acceptance and beam classification.
	assign busy   = (state_q != F_IDLE) || full || init_busy;
	assign accept = start && !busy;
	assign beam_ok = (32'(req.beam_index) < ogrc_pkg::MAX_BEAMS)
		&& (req.range_mm >= cfg.range_min_mm) && (req.range_mm <= cfg.range_max_mm);

	// Beam angle, folded into the right half plane.
	assign bprod  = 28'(req.beam_index) * 28'(cfg.angle_step);
	assign theta  = 16'(cfg.heading + cfg.angle_start + bprod[15:0]);
	assign fold   = theta[15] ^ theta[14];
	assign t_fold = fold ? {~theta[15], theta[14:0]} : theta;

	// One CORDIC micro-rotation per cycle.
	assign dx     = x_q >>> iter_q;
	assign dy     = y_q >>> iter_q;
	assign atan_i = ogrc_pkg::cordic_atan(iter_q);

	// Commands to the queue.
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (state_q == F_PUSH) begin
			push               = !full;
			push_data.kind     = ogrc_pkg::CMD_BEAM;
			push_data.cos_v    = neg_q ? -x_q : x_q;
			push_data.sin_v    = neg_q ? -y_q : y_q;
			push_data.range_mm = range_q;
		end else if (accept && (req.func == ogrc_pkg::FUNC_SCAN)) begin
			push           = 1'b1;
			push_data.kind = ogrc_pkg::CMD_SCAN;
		end else if (accept && (req.func == ogrc_pkg::FUNC_READ)) begin
			push                 = 1'b1;
			push_data.kind       = ogrc_pkg::CMD_READ;
			push_data.cell_index = req.cell_index;
		end
	end

	// Sequencer and rotation registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && (req.func == ogrc_pkg::FUNC_BEAM) && beam_ok) begin
						x_q     <= ogrc_pkg::CORDIC_K0;
						y_q     <= '0;
						z_q     <= ogrc_pkg::Z_W'($signed(t_fold)) <<< 8;
						neg_q   <= fold;
						range_q <= req.range_mm;
						iter_q  <= '0;
						state_q <= F_ROT;
					end
				end
				F_ROT: begin
					if (!z_q[ogrc_pkg::Z_W-1]) begin
						x_q <= x_q - dy;
						y_q <= y_q + dx;
						z_q <= z_q - atan_i;
					end else begin
						x_q <= x_q + dy;
						y_q <= y_q - dx;
						z_q <= z_q + atan_i;
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == ogrc_pkg::ITER_W'(ogrc_pkg::CORDIC_ITERS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// A rotation in flight always holds off new requests.
	a_busy_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != F_IDLE) |-> busy)
		else $error("front accepts while rotating");

endmodule

// ===== hdl/ogrc_fifo.sv =====
// ----------------------------------------------------------------------------
// Ray caster command queue
// A short in-order queue that decouples the front end from the marcher.
// ----------------------------------------------------------------------------
module ogrc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ogrc_pkg::cmd_t push_data,
	input  logic           pop,
	output ogrc_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);

	ogrc_pkg::cmd_t                  slot_q [ogrc_pkg::FIFO_DEPTH];
	logic [ogrc_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [ogrc_pkg::FIFO_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (ogrc_pkg::FIFO_PTR_W + 1)'(ogrc_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (ogrc_pkg::FIFO_PTR_W + 1)'(push) - (ogrc_pkg::FIFO_PTR_W + 1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");

endmodule

// ===== hdl/ogrc_back.sv =====
// ----------------------------------------------------------------------------
// Ray caster back end
// Owns the grid memory: clears it, marches beams through it sample by sample,
// and answers read requests.
// ----------------------------------------------------------------------------
module ogrc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ogrc_pkg::cfg_t cfg,
	input  logic           empty,
	input  ogrc_pkg::cmd_t head,
	output logic           pop,
	output logic           init_busy,
	output logic           done,
	output ogrc_pkg::rsp_t rsp
);

	typedef enum logic [3:0] {
		B_CLR,
		B_CTR,
		B_IDLE,
		B_RD,
		B_OUT,
		B_CHK,
		B_MUL,
		B_DSET,
		B_DIV,
		B_WR
	} bstate_t;

	bstate_t state_q;
	logic                          init_q;
	logic                          center_q;
	logic [ogrc_pkg::ADDR_W-1:0]   clr_q;
	ogrc_pkg::cmd_t                cmd_q;
	logic [16:0]                   r_q;
	logic [15:0]                   mr_q;
	logic [1:0]                    val_q;
	logic                          last_q;
	logic signed [ogrc_pkg::P_W-1:0] px_s1, py_s1;
	logic [ogrc_pkg::DIV_W-1:0]    nx_q, ny_q;
	logic [15:0]                   rx_q, ry_q;
	logic                          sx_q, sy_q;
	logic [ogrc_pkg::DIV_CW-1:0]   cnt_q;
	logic [1:0]                    rdata_q;

	logic [1:0]                    mem [ogrc_pkg::GRID_CELLS];

	logic [16:0]                   step;
	logic [15:0]                   csz;
	logic signed [50:0]            prodx, prody;
	logic [16:0]                   tx, ty;
	logic                          gx, gy;
	logic signed [ogrc_pkg::Q_W-1:0] resx, resy;
	logic                          inb;
	logic                          we;
	logic [ogrc_pkg::ADDR_W-1:0]   wa;
	logic [1:0]                    wd;

	// Zero step and zero cell size act as one.
	assign step = (cfg.march_step_mm == '0) ? 17'd1 : {1'b0, cfg.march_step_mm};
	assign csz  = (cfg.cell_size_mm == '0) ? 16'd1 : cfg.cell_size_mm;

	// Projection of the sample onto both axes.
	assign prodx = $signed({1'b0, mr_q}) * cmd_q.cos_v;
	assign prody = $signed({1'b0, mr_q}) * cmd_q.sin_v;

	// One restoring division step per cycle on each axis.
	assign tx = {rx_q, nx_q[ogrc_pkg::DIV_W-1]};
	assign ty = {ry_q, ny_q[ogrc_pkg::DIV_W-1]};
	assign gx = (tx >= {1'b0, csz});
	assign gy = (ty >= {1'b0, csz});

	// Floor quotient and grid bounds.
	assign resx = sx_q ? (-$signed({2'b00, nx_q}) - $signed(ogrc_pkg::Q_W'(rx_q != '0)))
		: $signed({2'b00, nx_q});
	assign resy = sy_q ? (-$signed({2'b00, ny_q}) - $signed(ogrc_pkg::Q_W'(ry_q != '0)))
		: $signed({2'b00, ny_q});
	assign inb = (resx >= -ogrc_pkg::HALF_W) && (resx < ogrc_pkg::HALF_W)
		&& (resy >= -ogrc_pkg::HALF_H) && (resy < ogrc_pkg::HALF_H);

	// Memory write port selection.
	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = ogrc_pkg::CELL_UNKNOWN;
		case (state_q)
			B_CLR: begin
				we = 1'b1;
			end
			B_CTR: begin
				we = 1'b1;
				wa = ogrc_pkg::ADDR_W'(ogrc_pkg::CENTER_ADDR);
				wd = ogrc_pkg::CELL_FREE;
			end
			B_WR: begin
				we = inb;
				wa = ogrc_pkg::ADDR_W'((32'(resy) + ogrc_pkg::HALF_H) * ogrc_pkg::MAP_W
					+ 32'(resx) + ogrc_pkg::HALF_W);
				wd = val_q;
			end
			default: we = 1'b0;
		endcase
	end

	// Grid memory with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ogrc_pkg::ADDR_W'(cmd_q.cell_index)];
	end

	assign pop       = (state_q == B_IDLE) && !empty;
	assign init_busy = init_q;
	assign done      = (state_q == B_OUT);
	assign rsp.cell_state = (32'(cmd_q.cell_index) < ogrc_pkg::GRID_CELLS) ? rdata_q
		: ogrc_pkg::CELL_UNKNOWN;
	assign rsp.read_index = cmd_q.cell_index;

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLR;
			init_q   <= 1'b1;
			center_q <= 1'b0;
			clr_q    <= '0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ogrc_pkg::ADDR_W'(ogrc_pkg::GRID_CELLS - 1)) begin
						init_q  <= 1'b0;
						state_q <= center_q ? B_CTR : B_IDLE;
					end
				end
				B_CTR: state_q <= B_IDLE;
				B_IDLE: begin
					if (!empty) begin
						cmd_q <= head;
						unique case (head.kind)
							ogrc_pkg::CMD_SCAN: begin
								clr_q    <= '0;
								center_q <= 1'b1;
								state_q  <= B_CLR;
							end
							ogrc_pkg::CMD_BEAM: begin
								r_q     <= {1'b0, cfg.range_min_mm};
								state_q <= B_CHK;
							end
							default: state_q <= B_RD;
						endcase
					end
				end
				B_RD:  state_q <= B_OUT;
				B_OUT: state_q <= B_IDLE;
				B_CHK: begin
					if ((r_q + step) < {1'b0, cmd_q.range_mm}) begin
						mr_q   <= r_q[15:0];
						val_q  <= ogrc_pkg::CELL_FREE;
						last_q <= 1'b0;
					end else begin
						mr_q   <= cmd_q.range_mm;
						val_q  <= ogrc_pkg::CELL_OCC;
						last_q <= 1'b1;
					end
					state_q <= B_MUL;
				end
				B_MUL: begin
					px_s1   <= prodx[ogrc_pkg::FRAC_SH + ogrc_pkg::P_W - 1:ogrc_pkg::FRAC_SH];
					py_s1   <= prody[ogrc_pkg::FRAC_SH + ogrc_pkg::P_W - 1:ogrc_pkg::FRAC_SH];
					state_q <= B_DSET;
				end
				B_DSET: begin
					sx_q    <= px_s1[ogrc_pkg::P_W-1];
					sy_q    <= py_s1[ogrc_pkg::P_W-1];
					nx_q    <= ogrc_pkg::DIV_W'(px_s1[ogrc_pkg::P_W-1] ? -px_s1 : px_s1);
					ny_q    <= ogrc_pkg::DIV_W'(py_s1[ogrc_pkg::P_W-1] ? -py_s1 : py_s1);
					rx_q    <= '0;
					ry_q    <= '0;
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					rx_q  <= gx ? 16'(tx - {1'b0, csz}) : tx[15:0];
					ry_q  <= gy ? 16'(ty - {1'b0, csz}) : ty[15:0];
					nx_q  <= {nx_q[ogrc_pkg::DIV_W-2:0], gx};
					ny_q  <= {ny_q[ogrc_pkg::DIV_W-2:0], gy};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ogrc_pkg::DIV_CW'(ogrc_pkg::DIV_W - 1)) begin
						state_q <= B_WR;
					end
				end
				B_WR: begin
					r_q     <= r_q + step;
					state_q <= last_q ? B_IDLE : B_CHK;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == B_RD))
		else $error("result without a read");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(init_q || (state_q == B_DIV)) |-> !pop)
		else $error("command taken while busy");

endmodule

// ===== hdl/lidar_occupancy_grid_raycast.sv =====
// ----------------------------------------------------------------------------
// Occupancy grid ray caster
// Keeps a scanner-centered grid of 2-bit cells, marks beams into it and
// returns single cells on request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. After reset the grid
// is cleared one cell per cycle, and busy stays high for that time. A begin-scan
// request clears the grid the same way. A beam runs through the front CORDIC,
// overlapped with the previous beam, and then through the back end once for
// every sample marked (one multiply, an 18-step divider and the write). A read
// is taken from the queue, its cell is read in the B_RD state, and its result
// is on rsp in the B_OUT state that follows, for exactly one cycle with done
// high; the receiver cannot stall it. Results come out in request order.
module lidar_occupancy_grid_raycast (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  ogrc_pkg::req_t                    req,
	output logic                              busy,
	output logic                              done,
	output ogrc_pkg::rsp_t                    rsp,
	input  logic                              cfg_we,
	input  logic [ogrc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [15:0]                       cfg_wdata
);

	ogrc_pkg::cfg_t cfg_q;
	ogrc_pkg::cmd_t push_data, head;
	logic           push, pop, full, empty, init_busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heading       <= 16'd0;
			cfg_q.angle_start   <= 16'sh8000;
			cfg_q.angle_step    <= 16'sd182;
			cfg_q.range_min_mm  <= 16'd100;
			cfg_q.range_max_mm  <= 16'd30000;
			cfg_q.cell_size_mm  <= 16'd100;
			cfg_q.march_step_mm <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ogrc_pkg::CFG_HEADING:     cfg_q.heading       <= cfg_wdata;
				ogrc_pkg::CFG_ANGLE_START: cfg_q.angle_start   <= cfg_wdata;
				ogrc_pkg::CFG_ANGLE_STEP:  cfg_q.angle_step    <= cfg_wdata;
				ogrc_pkg::CFG_RANGE_MIN:   cfg_q.range_min_mm  <= cfg_wdata;
				ogrc_pkg::CFG_RANGE_MAX:   cfg_q.range_max_mm  <= cfg_wdata;
				ogrc_pkg::CFG_CELL_SIZE:   cfg_q.cell_size_mm  <= cfg_wdata;
				ogrc_pkg::CFG_MARCH_STEP:  cfg_q.march_step_mm <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ogrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.cfg       (cfg_q),
		.init_busy (init_busy),
		.full      (full),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	ogrc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	ogrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.init_busy (init_busy),
		.done      (done),
		.rsp       (rsp)
	);

endmodule
